// ===== rtl/tcp_handshake_flow_tracker_defines.svh =====
// Assertion macros shared by the flow tracker RTL.
// Depends on: nothing; users must have signals named clock and reset in scope.
`ifndef TCP_HANDSHAKE_FLOW_TRACKER_DEFINES_SVH
`define TCP_HANDSHAKE_FLOW_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define THFT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define THFT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/thft_pkg.sv =====
// Shared types, codes and key helpers for the TCP handshake flow tracker.
// Depends on: nothing.
package thft_pkg;

   localparam int FLOW_ENTRIES = 64;
   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int KEY_W = 96;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);
   localparam logic [IDX_W:0] ENTRIES_EXT = (IDX_W + 1)'(FLOW_ENTRIES);

   // command codes
   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // bit positions in marks_set
   localparam int MARK_SYN    = 0;
   localparam int MARK_SYNACK = 1;
   localparam int MARK_ACK    = 2;

   typedef enum logic [1:0] {
      FS_NONE         = 2'd0,
      FS_SYN_SENT     = 2'd1,
      FS_SYN_RECEIVED = 2'd2,
      FS_ESTABLISHED  = 2'd3
   } flow_state_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic        command;
      logic        is_tcp_ip;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [31:0] dst_ip;
      logic [15:0] dst_port;
      logic        syn_flag;
      logic        ack_flag;
      logic [31:0] now_ms;
   } req_beat_type;

   typedef struct packed {
      flow_state_type flow_state;
      status_type     status;
      logic [31:0]    syn_to_synack_ms;
      logic [31:0]    synack_to_ack_ms;
   } rsp_beat_type;

   // one table entry: normalized key, handshake state and time marks
   typedef struct packed {
      logic [63:0]    key_addr;
      logic [31:0]    key_port;
      flow_state_type hs_state;
      logic [2:0]     marks_set;
      logic [31:0]    syn_ms;
      logic [31:0]    synack_ms;
      logic [31:0]    ack_ms;
   } flow_rec_type;

   typedef struct packed {
      logic    rd_en;
      logic    wr_en;
      idx_type rd_idx;
      idx_type wr_idx;
   } ram_cmd_type;

   // Direction-free key: {addr, addr, port, port} of the lower then the higher {ip, port} endpoint
   function automatic logic [KEY_W-1:0] norm_key(req_beat_type r);
      logic [47:0] se;
      logic [47:0] de;
      se = {r.src_ip, r.src_port};
      de = {r.dst_ip, r.dst_port};
      if (se <= de) begin
         return {r.src_ip, r.dst_ip, r.src_port, r.dst_port};
      end
      return {r.dst_ip, r.src_ip, r.dst_port, r.src_port};
   endfunction

   // XOR fold of the key into a home slot, kept below FLOW_ENTRIES
   function automatic idx_type hash_key(logic [KEY_W-1:0] k);
      logic [IDX_W-1:0] h;
      logic [IDX_W:0]   ext;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % IDX_W] = h[i % IDX_W] ^ k[i];
      end
      ext = {1'b0, h};
      if (ext >= ENTRIES_EXT) begin
         ext = ext - ENTRIES_EXT;
      end
      return ext[IDX_W-1:0];
   endfunction

endpackage

// ===== rtl/thft_flow_ram.sv =====
// Flow table storage: one synchronous record memory plus per-entry valid flops.
// Depends on: thft_pkg, tcp_handshake_flow_tracker_defines.svh.
`include "tcp_handshake_flow_tracker_defines.svh"

module thft_flow_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  thft_pkg::ram_cmd_type cmd,
   input  thft_pkg::flow_rec_type wr_rec,
   output thft_pkg::flow_rec_type rd_rec,
   output logic                  probe_valid
);

   thft_pkg::flow_rec_type flow_mem [thft_pkg::FLOW_ENTRIES];
   thft_pkg::flow_rec_type rd_rec_ff;
   logic [thft_pkg::FLOW_ENTRIES-1:0] valid_ff;

   // valid bits: cleared by reset, set on first write of an entry
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_idx] <= 1'b1;
      end
   end

   // record memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         flow_mem[cmd.wr_idx] <= wr_rec;
      end
      if (cmd.rd_en) begin
         rd_rec_ff <= flow_mem[cmd.rd_idx];
      end
   end

   assign rd_rec      = rd_rec_ff;
   assign probe_valid = valid_ff[cmd.rd_idx];

   `THFT_ASSERT_NXT(a_write_sets_valid, cmd.wr_en, valid_ff[$past(cmd.wr_idx)], "entry not valid")
   `THFT_ASSERT_IMP(a_no_rd_wr_overlap, cmd.rd_en, !cmd.wr_en, "read and write in one cycle")
   `THFT_ASSERT_NXT(a_valid_sticky, probe_valid, valid_ff[$past(cmd.rd_idx)], "valid bit cleared")

endmodule

// ===== rtl/tcp_handshake_flow_tracker.sv =====
// TCP handshake flow tracker: open-addressed flow table with linear probing.
// Steps: an invalid packet goes straight to S_FINISH; otherwise S_READ tests a slot's
// valid bit (empty ends the search) and S_CHECK compares its record, once per probe
// (at most FLOW_ENTRIES probes). One beat at a time: the next req beat is taken the
// cycle after the result enters the output register, which S_FINISH waits to be free.
// Reset: synchronous; clears control state and all entry valid bits. Uses thft_flow_ram.
`include "tcp_handshake_flow_tracker_defines.svh"

module tcp_handshake_flow_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  thft_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output thft_pkg::rsp_beat_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_FINISH
   } fsm_type;

   fsm_type                         state_ff, state_in;
   thft_pkg::req_beat_type          req_ff, req_in;
   logic [thft_pkg::KEY_W-1:0]      key_ff, key_in;
   thft_pkg::idx_type               probe_idx_ff, probe_idx_in;
   thft_pkg::idx_type               probe_cnt_ff, probe_cnt_in;
   thft_pkg::rsp_beat_type          res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   thft_pkg::rsp_beat_type          rsp_data_ff, rsp_data_in;

   logic [thft_pkg::KEY_W-1:0]      req_key;
   thft_pkg::ram_cmd_type           ram_cmd;
   thft_pkg::flow_rec_type          rd_rec;
   thft_pkg::flow_rec_type          base_rec;
   thft_pkg::flow_rec_type          upd_rec;
   logic                            probe_valid;
   logic                            key_hit;

   thft_flow_ram u_flow_ram (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ram_cmd),
      .wr_rec      (upd_rec),
      .rd_rec      (rd_rec),
      .probe_valid (probe_valid)
   );

   function automatic thft_pkg::rsp_beat_type err_rsp(thft_pkg::status_type st);
      thft_pkg::rsp_beat_type r;
      r.flow_state       = thft_pkg::FS_NONE;
      r.status           = st;
      r.syn_to_synack_ms = '0;
      r.synack_to_ack_ms = '0;
      return r;
   endfunction

   function automatic thft_pkg::rsp_beat_type rec_rsp(thft_pkg::flow_rec_type e);
      thft_pkg::rsp_beat_type r;
      r.flow_state = e.hs_state;
      r.status     = thft_pkg::STATUS_OK;
      r.syn_to_synack_ms = (e.marks_set[thft_pkg::MARK_SYN]
                            && e.marks_set[thft_pkg::MARK_SYNACK])
                           ? (e.synack_ms - e.syn_ms) : '0;
      r.synack_to_ack_ms = (e.marks_set[thft_pkg::MARK_SYNACK]
                            && e.marks_set[thft_pkg::MARK_ACK])
                           ? (e.ack_ms - e.synack_ms) : '0;
      return r;
   endfunction

   assign req_key = thft_pkg::norm_key(req_data);
   assign key_hit = (rd_rec.key_addr == key_ff[95:32]) && (rd_rec.key_port == key_ff[31:0]);

   // Entry to update: the read record on a hit, a fresh one on allocation
   always_comb begin
      if (state_ff == S_CHECK) begin
         base_rec = rd_rec;
      end else begin
         base_rec.key_addr  = key_ff[95:32];
         base_rec.key_port  = key_ff[31:0];
         base_rec.hs_state  = thft_pkg::FS_NONE;
         base_rec.marks_set = '0;
         base_rec.syn_ms    = '0;
         base_rec.synack_ms = '0;
         base_rec.ack_ms    = '0;
      end
   end

   // Handshake transitions; queries leave the record as read
   always_comb begin
      upd_rec = base_rec;
      if (req_ff.command == thft_pkg::CMD_PACKET) begin
         if (req_ff.syn_flag && !req_ff.ack_flag) begin
            upd_rec.syn_ms = req_ff.now_ms;
            upd_rec.marks_set[thft_pkg::MARK_SYN] = 1'b1;
            upd_rec.hs_state = thft_pkg::FS_SYN_SENT;
         end else if (req_ff.syn_flag && req_ff.ack_flag) begin
            upd_rec.synack_ms = req_ff.now_ms;
            upd_rec.marks_set[thft_pkg::MARK_SYNACK] = 1'b1;
            upd_rec.hs_state = thft_pkg::FS_SYN_RECEIVED;
         end else if (req_ff.ack_flag && base_rec.hs_state == thft_pkg::FS_SYN_RECEIVED) begin
            upd_rec.ack_ms = req_ff.now_ms;
            upd_rec.marks_set[thft_pkg::MARK_ACK] = 1'b1;
            upd_rec.hs_state = thft_pkg::FS_ESTABLISHED;
         end
      end
   end

   // Sequencer: hash, probe, read-modify-write, hand result to output register
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      key_in          = key_ff;
      probe_idx_in    = probe_idx_ff;
      probe_cnt_in    = probe_cnt_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      ram_cmd.rd_en   = 1'b0;
      ram_cmd.wr_en   = 1'b0;
      ram_cmd.rd_idx  = probe_idx_ff;
      ram_cmd.wr_idx  = probe_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               key_in       = req_key;
               probe_idx_in = thft_pkg::hash_key(req_key);
               probe_cnt_in = '0;
               if (req_data.command == thft_pkg::CMD_PACKET && !req_data.is_tcp_ip) begin
                  res_in   = err_rsp(thft_pkg::STATUS_INVALID);
                  state_in = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (!probe_valid) begin
               // empty slot ends the chain: flow is not in the table
               if (req_ff.command == thft_pkg::CMD_QUERY) begin
                  res_in = err_rsp(thft_pkg::STATUS_NOT_FOUND);
               end else begin
                  ram_cmd.wr_en = 1'b1;
                  res_in        = rec_rsp(upd_rec);
               end
               state_in = S_FINISH;
            end else begin
               ram_cmd.rd_en = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (key_hit) begin
               ram_cmd.wr_en = (req_ff.command == thft_pkg::CMD_PACKET);
               res_in        = rec_rsp(upd_rec);
               state_in      = S_FINISH;
            end else if (probe_cnt_ff == thft_pkg::LAST_IDX) begin
               // every slot probed and occupied by other flows
               res_in   = err_rsp((req_ff.command == thft_pkg::CMD_QUERY)
                                  ? thft_pkg::STATUS_NOT_FOUND : thft_pkg::STATUS_FULL);
               state_in = S_FINISH;
            end else begin
               probe_cnt_in = probe_cnt_ff + 1'b1;
               probe_idx_in = (probe_idx_ff == thft_pkg::LAST_IDX) ? '0 : probe_idx_ff + 1'b1;
               state_in     = S_READ;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      key_ff       <= key_in;
      probe_idx_ff <= probe_idx_in;
      probe_cnt_ff <= probe_cnt_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `THFT_ASSERT_NXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != S_IDLE, "stayed idle")
   `THFT_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH, "early rsp")
   `THFT_ASSERT_IMP(a_query_no_write, req_ff.command == thft_pkg::CMD_QUERY, !ram_cmd.wr_en, "query wr")

endmodule
